/* hw/rtl/swc_pkg.sv */
// Shared types, constants and the gradient table for the waterfall colormap unit.
// Depends on nothing; every other file of the unit imports it.
`timescale 1ns / 1ps

package swc_pkg;

	localparam int MAX_ROW_PIXELS = 2048;
	localparam int PALETTE_STEPS  = 256;

	localparam int SAMPLE_W   = 16;
	localparam int DB_SHIFT   = 7;
	localparam int DB_W       = SAMPLE_W - DB_SHIFT;
	localparam int LOW_W      = 9;
	localparam int LEVEL_W    = 10;
	localparam int SCALED_W   = LEVEL_W + DB_SHIFT;
	localparam int OFF_W      = SCALED_W;
	localparam int SUM_W      = 21;
	localparam int COUNT_W    = $clog2(MAX_ROW_PIXELS) + 1;
	localparam int AUTO_SPAN  = 50;
	localparam int COLOR_W    = 24;
	localparam int CH_W       = 8;
	localparam int ADDR_W     = 4;
	localparam int PDATA_W    = 32;

	localparam int IDX_W       = $clog2(PALETTE_STEPS);
	localparam int AVG_QUO_W   = 9;
	localparam int AVG_MAG_MAX = 256;
	localparam int QUO_W       = (IDX_W > AVG_QUO_W) ? IDX_W : AVG_QUO_W;
	localparam int DEN_W       = (OFF_W > COUNT_W) ? OFF_W : COUNT_W;
	localparam int NUM_W       = OFF_W + IDX_W;
	localparam int SHD_W       = DEN_W + QUO_W - 1;
	localparam int REM_W0      = (NUM_W > SHD_W) ? NUM_W : SHD_W;
	localparam int REM_W       = (REM_W0 > SUM_W) ? REM_W0 : SUM_W;
	localparam int STEP_W      = $clog2(QUO_W);

	localparam int PAL_D = PALETTE_STEPS - 1;

	localparam logic signed [LEVEL_W-1:0] LOW_RESET  = -10'sd140;
	localparam logic signed [LEVEL_W-1:0] HIGH_RESET = -10'sd90;

	localparam logic [COLOR_W-1:0] COLOR_BLACK  = 24'h000000;
	localparam logic [COLOR_W-1:0] COLOR_YELLOW = 24'hFFFF00;

	typedef enum logic [1:0] {
		REG_LOW  = 2'd0,
		REG_HIGH = 2'd1,
		REG_AUTO = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLS_BLACK  = 2'd0,
		CLS_YELLOW = 2'd1,
		CLS_MAP    = 2'd2
	} pix_class_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       row_end;
	} swc_in_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            row_last;
	} swc_out_t;

	typedef struct packed {
		logic capture;
		logic pix_load;
		logic div_step;
		logic latch_color;
		logic avg_load;
		logic avg_apply;
		logic emit;
	} swc_cmd_t;

	typedef struct packed {
		logic avg_due;
		logic out_blocked;
	} swc_stat_t;

	typedef struct packed {
		logic               wr_low;
		logic               wr_high;
		logic               wr_auto;
		logic [LEVEL_W-1:0] wdata;
	} swc_cfg_t;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] active_low;
		logic signed [LEVEL_W-1:0] active_high;
		logic                      auto_level;
	} swc_lvl_t;

	typedef logic [PALETTE_STEPS-1:0][COLOR_W-1:0] rom_t;

	// Piecewise black-blue-cyan-green-yellow-red-magenta gradient ending toward pale violet, floor of every value.
	function automatic rom_t build_rom();
		rom_t        rom;
		int unsigned t;
		int unsigned r;
		int unsigned g;
		int unsigned b;
		for (int i = 0; i < PALETTE_STEPS; i++) begin
			t = 9 * i;
			if (t < 2 * PAL_D) begin
				r = 0; g = 0; b = 255 * t / (2 * PAL_D);
			end else if (t < 3 * PAL_D) begin
				r = 0; g = 255 * (t - 2 * PAL_D) / PAL_D; b = 255;
			end else if (t < 4 * PAL_D) begin
				r = 0; g = 255; b = 255 * (4 * PAL_D - t) / PAL_D;
			end else if (t < 5 * PAL_D) begin
				r = 255 * (t - 4 * PAL_D) / PAL_D; g = 255; b = 0;
			end else if (t < 7 * PAL_D) begin
				r = 255; g = 255 * (7 * PAL_D - t) / (2 * PAL_D); b = 0;
			end else if (t < 8 * PAL_D) begin
				r = 255; g = 0; b = 255 * (t - 7 * PAL_D) / PAL_D;
			end else begin
				r = 255 * (12 * PAL_D - t) / (4 * PAL_D);
				g = 255 * (t - 8 * PAL_D) / (2 * PAL_D);
				b = 255;
			end
			if (r > 255) r = 255;
			if (g > 255) g = 255;
			if (b > 255) b = 255;
			rom[i] = {r[CH_W-1:0], g[CH_W-1:0], b[CH_W-1:0]};
		end
		return rom;
	endfunction

	localparam rom_t GRADIENT_ROM = build_rom();

endpackage

/* hw/rtl/spectrum_waterfall_colormap_unit.sv */
// Top level of the waterfall colormap unit: register port, controller and datapath.
// Depends on swc_pkg, swc_ctrl and swc_datapath.
//
//   Channel  Handshake                      Payload
//   in       in_valid / in_ready            in_data  (sample, row_end)
//   out      out_valid / out_ready          out_data (red, green, blue, row_last)
//   config   psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A request is captured, loaded into the divider and divided, and its color is latched; for the last
// pixel of a row with interior pixels in auto mode the row average then goes through the same divider
// before the result is written. The shared restoring divider works out one quotient bit per cycle.
// The next request can be accepted in the cycle after the result is written.
// A result waits in the output register while the next request is taken and worked on.
// The unit stalls in its final step only while an earlier result is still untaken.
// After reset the levels are -140 dB and -90 dB and auto mode is off.
`timescale 1ns / 1ps

module spectrum_waterfall_colormap_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [swc_pkg::ADDR_W-1:0]   paddr,
	input  logic [swc_pkg::PDATA_W-1:0]  pwdata,
	output logic [swc_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  swc_pkg::swc_in_t             in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output swc_pkg::swc_out_t            out_data
);
	import swc_pkg::*;

	swc_cmd_t   cmd;
	swc_stat_t  stat;
	swc_cfg_t   cfg;
	swc_lvl_t   lvl;
	logic       wr;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];

	assign cfg.wr_low  = wr && (idx == REG_LOW);
	assign cfg.wr_high = wr && (idx == REG_HIGH);
	assign cfg.wr_auto = wr && (idx == REG_AUTO);
	assign cfg.wdata   = pwdata[LEVEL_W-1:0];

	always_comb begin
		case (idx)
			REG_LOW:  prdata = PDATA_W'(lvl.active_low);
			REG_HIGH: prdata = PDATA_W'(lvl.active_high);
			REG_AUTO: prdata = PDATA_W'(lvl.auto_level);
			default:  prdata = '0;
		endcase
	end

	swc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	swc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg       (cfg),
		.lvl       (lvl),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* hw/rtl/swc_div.sv */
// Restoring divider shared by the pixel index and the row average, one quotient bit a step.
// Depends on swc_pkg for its widths.
`timescale 1ns / 1ps

module swc_div (
	input  logic                      clk,
	input  logic                      load,
	input  logic                      step,
	input  logic [swc_pkg::REM_W-1:0] num,
	input  logic [swc_pkg::DEN_W-1:0] den,
	output logic [swc_pkg::QUO_W-1:0] quo
);
	import swc_pkg::*;

	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic             fits;

	assign fits = (rem_q >= dsh_q);

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= num;
			dsh_q <= REM_W'(den) << (QUO_W - 1);
			quo_q <= '0;
		end else if (step) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QUO_W-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign quo = quo_q;

endmodule

/* hw/rtl/swc_datapath.sv */
// Datapath: working levels, row accumulator, shared divider, gradient lookup, output register.
// Depends on swc_pkg and swc_div; driven by commands from swc_ctrl.
`timescale 1ns / 1ps

module swc_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  swc_pkg::swc_cmd_t  cmd,
	output swc_pkg::swc_stat_t stat,
	input  swc_pkg::swc_cfg_t  cfg,
	output swc_pkg::swc_lvl_t  lvl,
	input  swc_pkg::swc_in_t   in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output swc_pkg::swc_out_t  out_data
);
	import swc_pkg::*;

	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       row_end_q;
	logic signed [LEVEL_W-1:0]  active_low_q;
	logic signed [LEVEL_W-1:0]  active_high_q;
	logic                       auto_level_q;
	logic signed [SUM_W-1:0]    level_sum_q;
	logic [COUNT_W-1:0]         level_count_q;
	logic                       at_row_start_q;
	pix_class_t                 class_q;
	logic                       zero_q;
	logic [COLOR_W-1:0]         color_q;
	logic                       out_valid_q;
	swc_out_t                   out_data_q;

	logic signed [SCALED_W:0]   s_ext;
	logic signed [SCALED_W:0]   lo_ext;
	logic signed [SCALED_W:0]   hi_ext;
	logic signed [SCALED_W:0]   off_full;
	logic signed [SCALED_W:0]   range_full;
	logic [OFF_W-1:0]           off;
	logic [OFF_W-1:0]           span;
	logic                       below;
	logic                       above;
	logic                       rnd;
	logic signed [DB_W-1:0]     s_db;
	logic                       add_en;
	logic [SUM_W-1:0]           sum_mag;
	logic signed [LEVEL_W-1:0]  avg_mag;
	logic signed [LEVEL_W-1:0]  new_low;
	logic [REM_W-1:0]           div_num;
	logic [DEN_W-1:0]           div_den;
	logic [QUO_W-1:0]           div_quo;

	assign s_ext      = (SCALED_W + 1)'(sample_q);
	assign lo_ext     = (SCALED_W + 1)'(active_low_q) <<< DB_SHIFT;
	assign hi_ext     = (SCALED_W + 1)'(active_high_q) <<< DB_SHIFT;
	assign off_full   = s_ext - lo_ext;
	assign range_full = hi_ext - lo_ext;
	assign off        = off_full[OFF_W-1:0];
	assign span       = range_full[OFF_W-1:0];
	assign below      = (s_ext < lo_ext);
	assign above      = (s_ext > hi_ext);

	// Whole dB, truncated toward zero.
	assign rnd    = sample_q[SAMPLE_W-1] & (|sample_q[DB_SHIFT-1:0]);
	assign s_db   = sample_q[SAMPLE_W-1:DB_SHIFT] + {{(DB_W - 1){1'b0}}, rnd};
	assign add_en = !at_row_start_q && !row_end_q
		&& (level_count_q < COUNT_W'(MAX_ROW_PIXELS - 2));

	assign sum_mag = level_sum_q[SUM_W-1] ? SUM_W'(-level_sum_q) : SUM_W'(level_sum_q);
	assign avg_mag = LEVEL_W'(div_quo);
	assign new_low = level_sum_q[SUM_W-1] ? -avg_mag : avg_mag;

	always_comb begin
		if (cmd.avg_load) begin
			div_num = REM_W'(sum_mag);
			div_den = DEN_W'(level_count_q);
		end else begin
			div_num = REM_W'(off) * REM_W'(PAL_D);
			div_den = DEN_W'(span);
		end
	end

	swc_div u_div (
		.clk  (clk),
		.load (cmd.pix_load | cmd.avg_load),
		.step (cmd.div_step),
		.num  (div_num),
		.den  (div_den),
		.quo  (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q  <= in_data.sample;
			row_end_q <= in_data.row_end;
		end
		if (cmd.pix_load) begin
			if (below) begin
				class_q <= CLS_BLACK;
			end else if (above) begin
				class_q <= CLS_YELLOW;
			end else begin
				class_q <= CLS_MAP;
			end
			zero_q <= (span == '0);
		end
		if (cmd.latch_color) begin
			case (class_q)
				CLS_BLACK:  color_q <= COLOR_BLACK;
				CLS_YELLOW: color_q <= COLOR_YELLOW;
				CLS_MAP: begin
					if (zero_q) begin
						color_q <= GRADIENT_ROM[0];
					end else begin
						color_q <= GRADIENT_ROM[div_quo[IDX_W-1:0]];
					end
				end
				default:    color_q <= COLOR_BLACK;
			endcase
		end
		if (cmd.emit) begin
			out_data_q.red      <= color_q[3*CH_W-1:2*CH_W];
			out_data_q.green    <= color_q[2*CH_W-1:CH_W];
			out_data_q.blue     <= color_q[CH_W-1:0];
			out_data_q.row_last <= row_end_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_low_q   <= LOW_RESET;
			active_high_q  <= HIGH_RESET;
			auto_level_q   <= 1'b0;
			level_sum_q    <= '0;
			level_count_q  <= '0;
			at_row_start_q <= 1'b1;
			out_valid_q    <= 1'b0;
		end else begin
			if (cmd.avg_apply) begin
				active_low_q  <= new_low;
				active_high_q <= new_low + LEVEL_W'(AUTO_SPAN);
			end else begin
				if (cfg.wr_low) begin
					active_low_q <= LEVEL_W'(signed'(cfg.wdata[LOW_W-1:0]));
				end
				if (cfg.wr_high) begin
					active_high_q <= signed'(cfg.wdata);
				end
			end
			if (cfg.wr_auto) begin
				auto_level_q <= cfg.wdata[0];
			end
			if (cmd.pix_load && add_en) begin
				level_sum_q   <= level_sum_q + SUM_W'(s_db);
				level_count_q <= level_count_q + COUNT_W'(1);
			end else if (cmd.emit && row_end_q) begin
				level_sum_q   <= '0;
				level_count_q <= '0;
			end
			if (cmd.emit) begin
				at_row_start_q <= row_end_q;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.avg_due     = row_end_q && auto_level_q && (level_count_q != '0);
	assign stat.out_blocked = out_valid_q && !out_ready;

	assign lvl.active_low  = active_low_q;
	assign lvl.active_high = active_high_q;
	assign lvl.auto_level  = auto_level_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_pix_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch_color && class_q == CLS_MAP && !zero_q
		|-> div_quo < QUO_W'(PALETTE_STEPS))
		else $error("pixel index above the gradient depth");

	a_avg_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.avg_apply |-> div_quo <= QUO_W'(AVG_MAG_MAX))
		else $error("row average out of the level range");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		level_count_q <= COUNT_W'(MAX_ROW_PIXELS - 2))
		else $error("row accumulator count beyond its cap");

endmodule

/* hw/rtl/swc_ctrl.sv */
// Controller state machine that sequences one request through the datapath.
// Depends on swc_pkg for the command and status structs.
`timescale 1ns / 1ps

module swc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  swc_pkg::swc_stat_t stat,
	output swc_pkg::swc_cmd_t  cmd
);
	import swc_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_PREP     = 8'b0000_0010,
		ST_PIX_DIV  = 8'b0000_0100,
		ST_PIX_DONE = 8'b0000_1000,
		ST_AVG_PREP = 8'b0001_0000,
		ST_AVG_DIV  = 8'b0010_0000,
		ST_AVG_DONE = 8'b0100_0000,
		ST_EMIT     = 8'b1000_0000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic [STEP_W-1:0] step_q;
	logic              last_step;

	assign last_step = (step_q == STEP_W'(QUO_W - 1));

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.pix_load = 1'b1;
				state_d      = ST_PIX_DIV;
			end
			ST_PIX_DIV: begin
				cmd.div_step = 1'b1;
				if (last_step) state_d = ST_PIX_DONE;
			end
			ST_PIX_DONE: begin
				cmd.latch_color = 1'b1;
				state_d         = stat.avg_due ? ST_AVG_PREP : ST_EMIT;
			end
			ST_AVG_PREP: begin
				cmd.avg_load = 1'b1;
				state_d      = ST_AVG_DIV;
			end
			ST_AVG_DIV: begin
				cmd.div_step = 1'b1;
				if (last_step) state_d = ST_AVG_DONE;
			end
			ST_AVG_DONE: begin
				cmd.avg_apply = 1'b1;
				state_d       = ST_EMIT;
			end
			ST_EMIT: begin
				if (!stat.out_blocked) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_step) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !stat.out_blocked)
		else $error("result written over an untaken result");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> step_q < STEP_W'(QUO_W))
		else $error("divider stepped past its quotient width");

	a_capture_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.pix_load)
		else $error("captured request not loaded into the divider");

endmodule

/* sim/swc_pixel_checker.sv */
// Checker for the waterfall colormap unit: tracks register writes, predicts every pixel color
// and compares the results in order. Depends on swc_pkg.
`timescale 1ns / 1ps

module swc_pixel_checker
	import swc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	input  logic                in_valid,
	input  logic                in_ready,
	input  swc_in_t             in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  swc_out_t            out_data,
	output int                  mismatches,
	output int                  pixels_left,
	output int                  pixels_checked,
	output int                  black_pixels,
	output int                  yellow_pixels,
	output int                  ramp_pixels,
	output int                  level_moves
);

	logic [COLOR_W-1:0] palette [PALETTE_STEPS];
	swc_out_t           pending_pixels [$];
	int                 lvl_low;
	int                 lvl_high;
	logic               auto_on;
	int                 db_sum;
	int                 db_count;
	logic               row_fresh;
	int                 n_bad;
	int                 n_checked;
	int                 n_black;
	int                 n_yellow;
	int                 n_ramp;
	int                 n_moves;

	assign mismatches     = n_bad;
	assign pixels_checked = n_checked;
	assign black_pixels   = n_black;
	assign yellow_pixels  = n_yellow;
	assign ramp_pixels    = n_ramp;
	assign level_moves    = n_moves;

	initial begin : fill_palette
		int d;
		int t;
		int r;
		int g;
		int b;
		d = PALETTE_STEPS - 1;
		n_bad = 0;
		n_checked = 0;
		n_black = 0;
		n_yellow = 0;
		n_ramp = 0;
		n_moves = 0;
		for (int i = 0; i < PALETTE_STEPS; i++) begin
			t = 9 * i;
			r = 255;
			g = 255;
			b = 255;
			case (t / d)
				0, 1: begin
					r = 0;
					g = 0;
					b = 255 * t / (2 * d);
				end
				2: begin
					r = 0;
					g = 255 * (t - 2 * d) / d;
				end
				3: begin
					r = 0;
					b = 255 * (4 * d - t) / d;
				end
				4: begin
					r = 255 * (t - 4 * d) / d;
					b = 0;
				end
				5, 6: begin
					g = 255 * (7 * d - t) / (2 * d);
					b = 0;
				end
				7: begin
					g = 0;
					b = 255 * (t - 7 * d) / d;
				end
				default: begin
					r = 255 * (12 * d - t) / (4 * d);
					g = 255 * (t - 8 * d) / (2 * d);
				end
			endcase
			if (r > 255) r = 255;
			if (g > 255) g = 255;
			if (b > 255) b = 255;
			palette[i] = {r[CH_W-1:0], g[CH_W-1:0], b[CH_W-1:0]};
		end
	end

	function automatic pix_class_t classify(input int s, output int idx);
		int lo;
		int hi;
		lo = lvl_low * (1 << DB_SHIFT);
		hi = lvl_high * (1 << DB_SHIFT);
		idx = 0;
		if (s < lo) return CLS_BLACK;
		if (s > hi) return CLS_YELLOW;
		if (hi > lo) idx = (s - lo) * (PALETTE_STEPS - 1) / (hi - lo);
		if (idx > PALETTE_STEPS - 1) idx = PALETTE_STEPS - 1;
		return CLS_MAP;
	endfunction

	task automatic note_bad(input string field, input int want_v, input int got_v);
		n_bad++;
		$display("%0t: pixel %0d %s expected %0d actual %0d",
			$time, n_checked, field, want_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		swc_out_t           want;
		pix_class_t         cls;
		logic [COLOR_W-1:0] rgb;
		int                 s;
		int                 idx;
		if (!arst_n) begin
			pending_pixels.delete();
			lvl_low = LOW_RESET;
			lvl_high = HIGH_RESET;
			auto_on = 1'b0;
			db_sum = 0;
			db_count = 0;
			row_fresh = 1'b1;
			pixels_left <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_LOW:  lvl_low = $signed(pwdata[LOW_W-1:0]);
					REG_HIGH: lvl_high = $signed(pwdata[LEVEL_W-1:0]);
					REG_AUTO: auto_on = pwdata[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_pixels.size() == 0) begin
					n_bad++;
					$display("%0t: pixel expected none actual %h", $time, out_data);
				end else begin
					want = pending_pixels.pop_front();
					if (out_data.red !== want.red) note_bad("red", want.red, out_data.red);
					if (out_data.green !== want.green)
						note_bad("green", want.green, out_data.green);
					if (out_data.blue !== want.blue) note_bad("blue", want.blue, out_data.blue);
					if (out_data.row_last !== want.row_last)
						note_bad("row_last", want.row_last, out_data.row_last);
				end
				n_checked++;
			end
			if (in_valid && in_ready) begin
				s = $signed(in_data.sample);
				if (!row_fresh && !in_data.row_end && db_count < MAX_ROW_PIXELS - 2) begin
					db_sum += s / (1 << DB_SHIFT);
					db_count++;
				end
				cls = classify(s, idx);
				case (cls)
					CLS_BLACK: begin
						rgb = COLOR_BLACK;
						n_black++;
					end
					CLS_YELLOW: begin
						rgb = COLOR_YELLOW;
						n_yellow++;
					end
					default: begin
						rgb = palette[idx];
						n_ramp++;
					end
				endcase
				want.red = rgb[3*CH_W-1:2*CH_W];
				want.green = rgb[2*CH_W-1:CH_W];
				want.blue = rgb[CH_W-1:0];
				want.row_last = in_data.row_end;
				pending_pixels.push_back(want);
				if (in_data.row_end) begin
					if (auto_on && db_count > 0) begin
						lvl_low = db_sum / db_count;
						lvl_high = lvl_low + AUTO_SPAN;
						n_moves++;
					end
					db_sum = 0;
					db_count = 0;
					row_fresh = 1'b1;
				end else begin
					row_fresh = 1'b0;
				end
			end
			pixels_left <= pending_pixels.size();
		end
	end

endmodule

/* sim/spectrum_waterfall_colormap_unit_test.sv */
// Testbench top for the waterfall colormap unit: clock, reset, register writes and pixel rows.
// Depends on swc_pkg, spectrum_waterfall_colormap_unit and swc_pixel_checker.
`timescale 1ns / 1ps

module spectrum_waterfall_colormap_unit_test;
	import swc_pkg::*;

	localparam int         LIMIT         = 1_000_000;
	localparam int         HOLD_CYCLES   = 400;
	localparam int         SETTLE_CYCLES = 30;
	localparam int         PHASE_PIXELS  = 500;
	localparam logic [1:0] REG_SPARE     = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	swc_in_t            in_data;
	logic               out_valid;
	logic               out_ready;
	swc_out_t           out_data;

	int   mismatches;
	int   pixels_left;
	int   pixels_checked;
	int   black_pixels;
	int   yellow_pixels;
	int   ramp_pixels;
	int   level_moves;
	int   tx_idle;
	int   rx_idle;
	int   drift_db;
	int   rows_sent;
	int   cycles = 0;
	logic hold_req;

	spectrum_waterfall_colormap_unit dut (.*);

	swc_pixel_checker u_checker (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : receiver
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	task automatic cfg_write(input logic [1:0] idx, input int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(input int sample, input logic last);
		swc_in_t req;
		req.sample = sample[SAMPLE_W-1:0];
		req.row_end = last;
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
		if (last) rows_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pixels_left != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_sample(input int base);
		int v;
		int pick;
		pick = $urandom_range(99);
		if (pick < 15) begin
			v = $signed(16'($urandom));
		end else if (pick < 20) begin
			case ($urandom_range(3))
				0: v = -32768;
				1: v = 32767;
				2: v = base * (1 << DB_SHIFT);
				default: v = (base + AUTO_SPAN) * (1 << DB_SHIFT);
			endcase
		end else begin
			v = base * (1 << DB_SHIFT) + int'($urandom_range(7000)) - 300;
		end
		if (v < -32768) v = -32768;
		if (v > 32767) v = 32767;
		return v;
	endfunction

	// Interior pixels from spike_from on are full scale, so a wrong cap on the row average shows.
	task automatic send_row(input int len, input int spike_from);
		for (int j = 0; j < len; j++) begin
			if (j >= spike_from && j < len - 1)
				send_pixel(32767, 1'b0);
			else
				send_pixel(pick_sample(drift_db), j == len - 1);
		end
	endtask

	task automatic run_rows(input int count);
		int sent;
		int len;
		int pick;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 10)
				len = 1;
			else if (pick < 20)
				len = 2;
			else
				len = $urandom_range(40, 3);
			if ($urandom_range(19) == 0)
				drift_db = int'($urandom_range(450)) - 250;
			else
				drift_db += int'($urandom_range(16)) - 8;
			if (drift_db < -250) drift_db = -250;
			if (drift_db > 200) drift_db = 200;
			send_row(len, len);
			sent += len;
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		hold_req = 1'b0;
		tx_idle = 0;
		rx_idle = 0;
		drift_db = -140;
		rows_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset levels, auto mode off: extremes, both level edges and one step past each.
		send_pixel(-32768, 1'b0);
		send_pixel(32767, 1'b0);
		send_pixel(-17920, 1'b0);
		send_pixel(-11520, 1'b0);
		send_pixel(-15000, 1'b0);
		send_pixel(-17921, 1'b0);
		send_pixel(-11519, 1'b1);
		send_pixel(0, 1'b1);
		settle();

		cfg_write(REG_LOW, -100);
		cfg_write(REG_HIGH, -100);
		cfg_write(REG_SPARE, 5);
		send_pixel(-12800, 1'b0);
		send_pixel(-12799, 1'b0);
		send_pixel(-12801, 1'b1);
		settle();

		// Inverted range with auto mode, then rows without interior pixels and
		// negative averages that truncate toward zero.
		cfg_write(REG_LOW, 50);
		cfg_write(REG_HIGH, 20);
		cfg_write(REG_AUTO, 1);
		send_pixel(6400, 1'b0);
		send_pixel(3000, 1'b0);
		send_pixel(2560, 1'b0);
		send_pixel(7000, 1'b1);
		send_pixel(100, 1'b0);
		send_pixel(200, 1'b1);
		send_pixel(300, 1'b1);
		send_pixel(-640, 1'b0);
		send_pixel(-645, 1'b0);
		send_pixel(-770, 1'b0);
		send_pixel(-1, 1'b1);
		settle();

		cfg_write(REG_LOW, -256);
		cfg_write(REG_HIGH, 511);
		cfg_write(REG_AUTO, 0);
		tx_idle = 32;
		rx_idle = 64;
		drift_db = 0;
		run_rows(PHASE_PIXELS);
		settle();

		cfg_write(REG_LOW, 255);
		cfg_write(REG_HIGH, -256);
		cfg_write(REG_AUTO, 1);
		tx_idle = 64;
		rx_idle = 32;
		run_rows(PHASE_PIXELS);
		settle();

		cfg_write(REG_LOW, -140);
		cfg_write(REG_HIGH, -90);
		cfg_write(REG_AUTO, 1);
		tx_idle = 0;
		rx_idle = 0;
		drift_db = -140;
		hold_req = 1'b1;
		run_rows(PHASE_PIXELS);
		send_row(12, 6);
		send_row(4, 4);
		settle();

		$display("Checked %0d pixels in %0d rows: %0d black, %0d yellow, %0d from the gradient.",
			pixels_checked, rows_sent, black_pixels, yellow_pixels, ramp_pixels);
		$display("Auto mode moved the levels %0d times, including after a row of full-scale pixels.",
			level_moves);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
